[sv/fsc_pkg.sv]
// Shared types and constants for the frustum sphere culling block.
package fsc_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_PLANES    = 6;

    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_REBUILD = 2'd1;
    localparam logic [1:0] REQ_TEST    = 2'd2;

    localparam logic [31:0] NORM_ONE = 32'h4000_0000;

    // One frustum plane: normal in Q2.30, offset in Q16.16.
    typedef struct packed {
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nz;
        logic signed [31:0] off;
    } t_plane;

    // Plane generator status toward the top level.
    typedef struct packed {
        logic beat;  // a finished plane is on the plane bus
        logic done;  // last plane of the rebuild
    } t_pg_stat;

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        mag33 = v[32] ? 33'(-v) : 33'(v);
    endfunction

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        if (v > 33'sh0_7FFF_FFFF) begin
            sat33 = 32'sh7FFF_FFFF;
        end else if (v < -33'sh0_8000_0000) begin
            sat33 = 32'sh8000_0000;
        end else begin
            sat33 = v[31:0];
        end
    endfunction

endpackage

[sv/fsc_cell.sv]
// One plane cell of the plane chain.
module fsc_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_shift,
    input  fsc_pkg::t_plane i_plane,
    output fsc_pkg::t_plane o_plane
);

    fsc_pkg::t_plane r_plane;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane <= '0;
        end else if (i_shift) begin
            r_plane <= i_plane;
        end
    end

    assign o_plane = r_plane;

endmodule

[sv/fsc_planegen.sv]
// Matrix store and plane rebuild engine: sums, isqrt and restoring divides.
module fsc_planegen #(
    parameter int FRAC_BITS = fsc_pkg::FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic [3:0]        i_wr_idx,
    input  logic [31:0]       i_wr_val,
    input  logic              i_go,
    output fsc_pkg::t_plane   o_plane,
    output fsc_pkg::t_pg_stat o_stat
);

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_SQ, S_SQRT, S_DLOAD, S_DIV, S_EMIT
    } t_state;

    t_state              r_state;
    logic [31:0]         r_mem [16];
    logic [15:0]         r_mvalid;
    logic [31:0]         r_rdata;
    logic [2:0]          r_p;
    logic [6:0]          r_cnt;
    logic [1:0]          r_k;
    logic signed [32:0]  r_m3;
    logic signed [32:0]  r_a [4];
    logic [1:0]          r_sh;
    logic [63:0]         r_acc;
    logic [33:0]         r_rem;
    logic [31:0]         r_root;
    logic [33:0]         r_den;
    logic [63:0]         r_num;
    logic [63:0]         r_q;
    logic signed [31:0]  r_pl [4];

    logic [1:0]  w_col;
    logic [3:0]  w_addr;
    logic [2:0]  w_prev;
    logic        w_plus;
    logic [32:0] w_mag0, w_mag1, w_mag2, w_mx, w_magk;
    logic [30:0] w_t;
    logic [35:0] w_sq_rem, w_sq_trial;
    logic [34:0] w_d_rem;
    logic [31:0] w_res;
    logic        w_neg;

    assign w_plus = ~r_p[0];
    assign w_col  = r_cnt[0] ? r_p[2:1] : 2'd3;
    assign w_addr = {r_cnt[2:1], w_col};
    assign w_prev = 3'(r_cnt - 7'd1);

    assign w_mag0 = fsc_pkg::mag33(r_a[0]);
    assign w_mag1 = fsc_pkg::mag33(r_a[1]);
    assign w_mag2 = fsc_pkg::mag33(r_a[2]);
    assign w_mx   = (w_mag0 > w_mag1) ? ((w_mag0 > w_mag2) ? w_mag0 : w_mag2)
                                      : ((w_mag1 > w_mag2) ? w_mag1 : w_mag2);
    assign w_magk = fsc_pkg::mag33(r_a[r_k]);
    // squaring steps k = 1..3 take normal components 0..2
    assign w_t    = 31'(fsc_pkg::mag33(r_a[r_k - 2'd1]) >> r_sh);

    assign w_sq_rem   = {r_rem, r_acc[63:62]};
    assign w_sq_trial = {2'b00, r_root, 2'b01};
    assign w_d_rem    = {r_rem, r_num[63]};

    // Signed, clamped result of the finished divide.
    always_comb begin
        w_neg = r_a[r_k][32];
        if (r_k != 2'd3) begin
            w_res = (r_q > 64'(fsc_pkg::NORM_ONE)) ? fsc_pkg::NORM_ONE : r_q[31:0];
            w_res = w_neg ? -w_res : w_res;
        end else if (w_neg) begin
            w_res = (r_q > 64'h8000_0000) ? 32'h8000_0000 : 32'(-r_q);
        end else begin
            w_res = (r_q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : r_q[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_val;
        end
        r_rdata <= r_mvalid[w_addr] ? r_mem[w_addr] : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mvalid <= '0;
            r_p      <= '0;
            r_cnt    <= '0;
            r_k      <= '0;
        end else begin
            if (i_wr_en) begin
                r_mvalid[i_wr_idx] <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_go) begin
                        r_p     <= '0;
                        r_cnt   <= '0;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (r_cnt != 7'd0) begin
                        if (!w_prev[0]) begin
                            r_m3 <= 33'($signed(r_rdata));
                        end else if (w_plus) begin
                            r_a[w_prev[2:1]] <= r_m3 + 33'($signed(r_rdata));
                        end else begin
                            r_a[w_prev[2:1]] <= r_m3 - 33'($signed(r_rdata));
                        end
                    end
                    if (r_cnt == 7'd8) begin
                        r_cnt   <= '0;
                        r_k     <= '0;
                        r_acc   <= '0;
                        r_state <= S_SQ;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                S_SQ: begin
                    if (r_k == 2'd0) begin
                        // shift search only needs the first step, k = 0
                        r_sh  <= w_mx[32] ? 2'd2 : (w_mx[31] ? 2'd1 : 2'd0);
                        r_k   <= 2'd1;
                    end else begin
                        r_acc <= r_acc + 64'(w_t) * 64'(w_t);
                        if (r_k == 2'd3) begin
                            r_k     <= '0;
                            r_cnt   <= '0;
                            r_rem   <= '0;
                            r_root  <= '0;
                            r_state <= S_SQRT;
                        end else begin
                            r_k <= r_k + 2'd1;
                        end
                    end
                end
                S_SQRT: begin
                    r_acc <= {r_acc[61:0], 2'b00};
                    if (w_sq_rem >= w_sq_trial) begin
                        r_rem  <= 34'(w_sq_rem - w_sq_trial);
                        r_root <= {r_root[30:0], 1'b1};
                    end else begin
                        r_rem  <= w_sq_rem[33:0];
                        r_root <= {r_root[30:0], 1'b0};
                    end
                    if (r_cnt == 7'd31) begin
                        r_state <= S_DLOAD;
                    end
                    r_cnt <= r_cnt + 7'd1;
                end
                S_DLOAD: begin
                    if (r_root == 32'd0) begin
                        r_pl[0] <= '0;
                        r_pl[1] <= '0;
                        r_pl[2] <= '0;
                        r_pl[3] <= fsc_pkg::sat33(r_a[3]);
                        r_state <= S_EMIT;
                    end else begin
                        r_den   <= 34'(r_root) << r_sh;
                        r_num   <= (r_k == 2'd3) ? (64'(w_magk) << FRAC_BITS)
                                                 : (64'(w_magk) << 30);
                        r_rem   <= '0;
                        r_q     <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_cnt == 7'd64) begin
                        r_pl[r_k] <= w_res;
                        r_k       <= r_k + 2'd1;
                        r_state   <= (r_k == 2'd3) ? S_EMIT : S_DLOAD;
                    end else begin
                        r_num <= {r_num[62:0], 1'b0};
                        if (w_d_rem >= {1'b0, r_den}) begin
                            r_rem <= 34'(w_d_rem - {1'b0, r_den});
                            r_q   <= {r_q[62:0], 1'b1};
                        end else begin
                            r_rem <= w_d_rem[33:0];
                            r_q   <= {r_q[62:0], 1'b0};
                        end
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                S_EMIT: begin
                    r_k   <= '0;
                    r_cnt <= '0;
                    r_p   <= r_p + 3'd1;
                    r_state <= (r_p == 3'(fsc_pkg::NUM_PLANES - 1)) ? S_IDLE : S_LOAD;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_plane.nx  = r_pl[0];
    assign o_plane.ny  = r_pl[1];
    assign o_plane.nz  = r_pl[2];
    assign o_plane.off = r_pl[3];
    assign o_stat.beat = (r_state == S_EMIT);
    assign o_stat.done = (r_state == S_EMIT) && (r_p == 3'(fsc_pkg::NUM_PLANES - 1));

endmodule

[sv/frustum_sphere_culling.sv]
// Top level of the frustum sphere culling block: command port, plane chain, sphere test.
//
// Usage: one command beat is taken when start is high and busy is low.
//   i_req_type selects the command:
//   - write: stores i_elem_value into matrix element i_elem_index in the
//     same cycle; busy stays low, no result.
//   - rebuild: forms the six frustum planes from the matrix. Each plane is built
//     by loading and summing matrix terms, squaring, 32 square root steps,
//     four divides with their setup and an emit step; a plane with a zero
//     normal skips the divides. No result.
//   - test: the six planes circulate once around the cell chain, one dot
//     product per cycle; o_valid rises together with the final o_visible;
//     busy drops together with that pulse, so the next test beat can follow.
//   A result stands for exactly one cycle; the receiver cannot stall it.
// Reset (i_rst_n low, synchronous) clears the matrix and all planes to zero,
// so every sphere reads as visible until a rebuild.
module frustum_sphere_culling #(
    parameter int FRAC_BITS = fsc_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_req_type,
    input  logic [3:0]         i_elem_index,
    input  logic signed [31:0] i_elem_value,
    input  logic signed [31:0] i_center_x,
    input  logic signed [31:0] i_center_y,
    input  logic signed [31:0] i_center_z,
    input  logic [30:0]        i_sphere_radius,
    output logic               o_valid,
    output logic               o_visible
);

    typedef enum logic [1:0] {T_IDLE, T_BUILD, T_TEST, T_FIN} t_state;

    t_state             r_state;
    logic [2:0]         r_cnt;
    logic signed [31:0] r_cx, r_cy, r_cz;
    logic [30:0]        r_rad;
    logic               r_pv;
    logic signed [63:0] r_px, r_py, r_pz;
    logic signed [31:0] r_poff;
    logic               r_vis;
    logic               r_valid;

    logic               w_acc;
    logic               w_shift;
    logic signed [65:0] w_d, w_lim;
    fsc_pkg::t_plane    w_pg_plane, w_feed;
    fsc_pkg::t_pg_stat  w_pg_stat;
    fsc_pkg::t_plane    w_cell [fsc_pkg::NUM_PLANES];

    assign w_acc = start && !busy;

    fsc_planegen #(.FRAC_BITS(FRAC_BITS)) u_pg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (w_acc && (i_req_type == fsc_pkg::REQ_WRITE)),
        .i_wr_idx (i_elem_index),
        .i_wr_val (i_elem_value),
        .i_go     (w_acc && (i_req_type == fsc_pkg::REQ_REBUILD)),
        .o_plane  (w_pg_plane),
        .o_stat   (w_pg_stat)
    );

    // Chain shifts toward cell 0; cell 0 feeds back during a test,
    // new planes enter at the tail during a rebuild.
    assign w_shift = w_pg_stat.beat || (r_state == T_TEST);
    assign w_feed  = w_pg_stat.beat ? w_pg_plane : w_cell[0];

    for (genvar g = 0; g < fsc_pkg::NUM_PLANES; g++) begin : g_cell
        fsc_pkg::t_plane w_in;
        if (g == fsc_pkg::NUM_PLANES - 1) begin : g_tail
            assign w_in = w_feed;
        end else begin : g_body
            assign w_in = w_cell[g + 1];
        end
        fsc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_plane (w_in),
            .o_plane (w_cell[g])
        );
    end

    // Stage two: plane distance against minus radius, all in Q*.46 scale.
    assign w_d   = 66'(r_px) + 66'(r_py) + 66'(r_pz) + (66'(r_poff) <<< 30);
    assign w_lim = -$signed(66'(r_rad) << 30);

    always_ff @(posedge i_clk) begin
        if (r_state == T_TEST) begin
            r_px   <= w_cell[0].nx * r_cx;
            r_py   <= w_cell[0].ny * r_cy;
            r_pz   <= w_cell[0].nz * r_cz;
            r_poff <= w_cell[0].off;
        end
        if (w_acc) begin
            r_cx  <= i_center_x;
            r_cy  <= i_center_y;
            r_cz  <= i_center_z;
            r_rad <= i_sphere_radius;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
            r_cnt   <= '0;
            r_pv    <= 1'b0;
            r_vis   <= 1'b1;
            r_valid <= 1'b0;
        end else begin
            r_valid <= (r_state == T_FIN);
            r_pv    <= (r_state == T_TEST);
            if (r_pv && (w_d < w_lim)) begin
                r_vis <= 1'b0;
            end
            unique case (r_state)
                T_IDLE: begin
                    if (w_acc && (i_req_type == fsc_pkg::REQ_REBUILD)) begin
                        r_state <= T_BUILD;
                    end else if (w_acc && (i_req_type == fsc_pkg::REQ_TEST)) begin
                        r_cnt   <= '0;
                        r_vis   <= 1'b1;
                        r_state <= T_TEST;
                    end
                end
                T_BUILD: begin
                    if (w_pg_stat.done) begin
                        r_state <= T_IDLE;
                    end
                end
                T_TEST: begin
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'(fsc_pkg::NUM_PLANES - 1)) begin
                        r_state <= T_FIN;
                    end
                end
                T_FIN: begin
                    // last compare lands here; result strobe follows
                    r_state <= T_IDLE;
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    assign busy      = (r_state != T_IDLE);
    assign o_valid   = r_valid;
    assign o_visible = r_vis;

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_state == T_IDLE))
        else $error("result pulse while busy");

    a_test_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_req_type == fsc_pkg::REQ_TEST)) |=> (r_state == T_TEST))
        else $error("test beat not started");

    a_beat_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pg_stat.beat |-> (r_state == T_BUILD))
        else $error("plane beat outside rebuild");

    a_test_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == T_FIN) |=> r_valid)
        else $error("missing result after test");

endmodule

[tb/frustum_sphere_culling_tb.sv]
// Testbench for frustum_sphere_culling: directed table plus random commands, predictor-checked.
`timescale 1ns / 1ps

module frustum_sphere_culling_tb;

    localparam int FB = 16;
    localparam logic [1:0] REQ_NONE = 2'd3;  // unused request code

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_req_type = fsc_pkg::REQ_WRITE;
    logic [3:0]         i_elem_index = '0;
    logic signed [31:0] i_elem_value = '0;
    logic signed [31:0] i_center_x = '0;
    logic signed [31:0] i_center_y = '0;
    logic signed [31:0] i_center_z = '0;
    logic [30:0]        i_sphere_radius = '0;
    logic               o_valid;
    logic               o_visible;

    frustum_sphere_culling #(.FRAC_BITS(FB)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req_type(i_req_type), .i_elem_index(i_elem_index),
        .i_elem_value(i_elem_value), .i_center_x(i_center_x),
        .i_center_y(i_center_y), .i_center_z(i_center_z),
        .i_sphere_radius(i_sphere_radius), .o_valid(o_valid), .o_visible(o_visible)
    );

    always #2 i_clk = ~i_clk;

    // One command beat.
    typedef struct {
        logic [1:0]         req;
        logic [3:0]         idx;
        logic signed [31:0] val;
        logic signed [31:0] cx, cy, cz;
        logic [30:0]        rad;
        int                 want;  // -1: take the predictor's answer
    } t_cmd;

    // Predictor state.
    logic signed [31:0] mat_m [16];
    logic signed [31:0] pl_m  [24];
    logic               vis_q [$];
    int                 n_err = 0;
    int                 sender_idle_pct = 0;

    task automatic report(input string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        n_err++;
    endtask

    function automatic longint unsigned root64(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint sat_w(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Gribb-Hartmann extraction: plane p uses column p/2, even p adds, odd p subtracts.
    task automatic rebuild_planes();
        longint a [4];
        longint unsigned mag, mx, sum, len, t;
        longint dn, n;
        int sh;
        for (int p = 0; p < fsc_pkg::NUM_PLANES; p++) begin
            mx = 0;
            sum = 0;
            sh = 0;
            for (int k = 0; k < 4; k++)
                a[k] = (p % 2 == 0) ? longint'(mat_m[k*4+3]) + longint'(mat_m[k*4+p/2])
                                    : longint'(mat_m[k*4+3]) - longint'(mat_m[k*4+p/2]);
            for (int k = 0; k < 3; k++) begin
                mag = a[k] < 0 ? -a[k] : a[k];
                if (mag > mx) mx = mag;
            end
            while ((mx >> sh) >= (64'd1 << 31)) sh++;
            for (int k = 0; k < 3; k++) begin
                mag = a[k] < 0 ? -a[k] : a[k];
                t = mag >> sh;
                sum += t * t;
            end
            len = root64(sum);
            if (len == 0) begin
                for (int k = 0; k < 3; k++) pl_m[p*4+k] = '0;
                pl_m[p*4+3] = 32'(sat_w(a[3]));
            end else begin
                dn = longint'(len << sh);
                for (int k = 0; k < 3; k++) begin
                    n = (a[k] * (64'sd1 << 30)) / dn;
                    if (n > (64'sd1 << 30)) n = 64'sd1 << 30;
                    if (n < -(64'sd1 << 30)) n = -(64'sd1 << 30);
                    pl_m[p*4+k] = 32'(n);
                end
                pl_m[p*4+3] = 32'(sat_w((a[3] * (64'sd1 << FB)) / dn));
            end
        end
    endtask

    function automatic logic sphere_visible(input t_cmd c);
        longint lim, d;
        lim = -(longint'(c.rad) * (64'sd1 << 30));
        for (int p = 0; p < fsc_pkg::NUM_PLANES; p++) begin
            d = longint'(pl_m[p*4]) * longint'(c.cx) + longint'(pl_m[p*4+1]) * longint'(c.cy)
              + longint'(pl_m[p*4+2]) * longint'(c.cz)
              + longint'(pl_m[p*4+3]) * (64'sd1 << 30);
            if (d < lim) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Drive one beat at the falling edge, hold until accepted, update the predictor.
    // start stays high after the beat; only an idle cycle or drain() drops it.
    task automatic send(input t_cmd c);
        logic v;
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start        <= 1'b1;
        i_req_type   <= c.req;
        i_elem_index <= c.idx;
        i_elem_value <= c.val;
        i_center_x   <= c.cx;
        i_center_y   <= c.cy;
        i_center_z   <= c.cz;
        i_sphere_radius <= c.rad;
        do @(posedge i_clk); while (busy);
        case (c.req)
            fsc_pkg::REQ_WRITE:   mat_m[c.idx] = c.val;
            fsc_pkg::REQ_REBUILD: rebuild_planes();
            fsc_pkg::REQ_TEST: begin
                v = sphere_visible(c);
                if (c.want >= 0 && v !== c.want[0])
                    report($sformatf("predictor gives %0b, table says %0d", v, c.want));
                vis_q = {vis_q, v};
            end
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Result checker: results arrive as single-cycle strobes.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (vis_q.size() == 0) begin
                report("result beat with nothing expected");
            end else if (o_visible !== vis_q[0]) begin
                report($sformatf("visible %b, expected %b", o_visible, vis_q[0]));
                void'(vis_q.pop_front());
            end else begin
                void'(vis_q.pop_front());
            end
        end
    end

    function automatic t_cmd mk(input logic [1:0] rq, input logic [3:0] ix,
                                input logic signed [31:0] vl, input int w);
        t_cmd c;
        c.req = rq; c.idx = ix; c.val = vl;
        c.cx = $urandom; c.cy = $urandom; c.cz = $urandom;
        c.rad = 31'($urandom); c.want = w;
        return c;
    endfunction

    function automatic t_cmd mk_test(input logic signed [31:0] x, y, z,
                                     input logic [30:0] r, input int w);
        t_cmd c;
        c = mk(fsc_pkg::REQ_TEST, 4'($urandom), $urandom, w);
        c.cx = x; c.cy = y; c.cz = z; c.rad = r;
        return c;
    endfunction

    // Random field value biased toward extremes and small magnitudes.
    function automatic logic signed [31:0] pick32();
        case ($urandom_range(7))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return '0;
            3, 4: return $signed($urandom_range(32'h0002_0000)) - 32'sh0001_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_cmd();
        t_cmd c;
        int k;
        k = $urandom_range(99);
        if (k < 2) begin
            c = mk(REQ_NONE, 4'($urandom), $urandom, -1);  // unused code, ignored
        end else if (k < 30) begin
            c = mk(fsc_pkg::REQ_WRITE, 4'($urandom), pick32(), -1);
        end else if (k < 33) begin
            c = mk(fsc_pkg::REQ_REBUILD, 4'($urandom), $urandom, -1);
        end else begin
            c = mk_test(pick32(), pick32(), pick32(),
                        $urandom_range(3) == 0 ? 31'($urandom) : 31'($urandom_range(32'h40_0000)),
                        -1);
        end
        send(c);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (vis_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    t_cmd dir_tab [$];

    task automatic add_row(input t_cmd c);
        dir_tab = {dir_tab, c};
    endtask

    initial begin
        for (int i = 0; i < 16; i++) mat_m[i] = '0;
        for (int i = 0; i < 24; i++) pl_m[i] = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // After reset every sphere is visible.
        add_row(mk_test(32'sh8000_0000, 32'sh7FFF_FFFF, '0, '0, 1));
        // Zero matrix rebuild: zero normals, offsets zero, still visible.
        add_row(mk(fsc_pkg::REQ_REBUILD, '0, '0, -1));
        add_row(mk_test('0, '0, '0, 31'h7FFF_FFFF, 1));
        // Only w column set: zero-normal planes keep a raw, positive offset.
        add_row(mk(fsc_pkg::REQ_WRITE, 4'd15, 32'sh0001_0000, -1));
        add_row(mk(fsc_pkg::REQ_REBUILD, '0, '0, -1));
        add_row(mk_test(32'sh7FFF_FFFF, '0, '0, '0, 1));
        // Identity matrix: unit cube frustum.
        add_row(mk(fsc_pkg::REQ_WRITE, 4'd0,  32'sh0001_0000, -1));
        add_row(mk(fsc_pkg::REQ_WRITE, 4'd5,  32'sh0001_0000, -1));
        add_row(mk(fsc_pkg::REQ_WRITE, 4'd10, 32'sh0001_0000, -1));
        add_row(mk(REQ_NONE, 4'd10, 32'sh8000_0000, -1));  // ignored
        add_row(mk(fsc_pkg::REQ_REBUILD, '0, '0, -1));
        add_row(mk_test('0, '0, '0, '0, -1));
        add_row(mk_test(32'sh0005_0000, '0, '0, 31'h0001_0000, -1));
        add_row(mk_test(32'sh0005_0000, '0, '0, 31'h0004_8000, -1));
        add_row(mk_test(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, '0, -1));
        // Full-scale elements: the normal magnitudes need the right shift.
        add_row(mk(fsc_pkg::REQ_WRITE, 4'd3,  32'sh7FFF_FFFF, -1));
        add_row(mk(fsc_pkg::REQ_WRITE, 4'd0,  32'sh7FFF_FFFF, -1));
        add_row(mk(fsc_pkg::REQ_WRITE, 4'd7,  32'sh8000_0000, -1));
        add_row(mk(fsc_pkg::REQ_WRITE, 4'd4,  32'sh8000_0000, -1));
        add_row(mk(fsc_pkg::REQ_WRITE, 4'd11, 32'sh7FFF_FFFF, -1));
        add_row(mk(fsc_pkg::REQ_REBUILD, '0, '0, -1));
        add_row(mk_test(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                        31'h7FFF_FFFF, -1));
        add_row(mk_test(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, '0, -1));
        foreach (dir_tab[i]) send(dir_tab[i]);
        drain();

        // Random phases: no idling, sender idle 54%, 25%, then none again.
        for (int ph = 0; ph < 4; ph++) begin
            sender_idle_pct = (ph == 1) ? 54 : (ph == 2) ? 25 : 0;
            for (int n = 0; n < 440; n++) random_cmd();
        end

        drain();
        if (n_err == 0) begin
            $display("PASS frustum_sphere_culling");
        end else begin
            $display("FAIL frustum_sphere_culling");
        end
        $finish;
    end

    // Rebuilds, the longest commands, are about 3% of commands: well under the timeout below.
    initial begin
        #20ms;
        $display("FAIL frustum_sphere_culling");
        $finish;
    end

endmodule
